FILE: src/bitmap_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent check helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bitmap_block_allocator: check failed");
// Next-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bitmap_block_allocator: check failed");
`else
`define BBA_ASSERT_IMP(lbl, a, b)
`define BBA_ASSERT_NXT(lbl, a, b)
`endif

`endif

FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, operation and status codes, and the command and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 7;
  localparam int TOT_W  = 11;
  localparam int ST_W   = 2;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;

  localparam logic [TOT_W-1:0] RESET_TOTAL = 11'd1024;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  // Command kinds after classification
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [ST_W-1:0]  status;
    logic             last;
  } res_t;

  typedef struct packed {
    logic init_done;
    logic busy;
  } bk_status_t;

endpackage

`default_nettype wire

FILE: src/bba_front.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator front end
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_front #(
  parameter int MAX_REQUEST = 64
) (
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic                       op,
  input  wire logic [bba_pkg::CNT_W-1:0]  count,
  input  wire logic [bba_pkg::IDX_W-1:0]  block_index,
  input  wire logic [bba_pkg::TOT_W-1:0]  lim,
  input  wire bba_pkg::bk_status_t        bk_stat,
  input  wire logic                       q_ready,
  output logic                            q_push,
  output bba_pkg::cmd_t                   q_cmd
);

  localparam logic [bba_pkg::CNT_W-1:0] MAX_REQ = bba_pkg::CNT_W'(MAX_REQUEST);

  // Hold off while the bitmap is being cleared
  assign in_tready = q_ready && bk_stat.init_done;
  assign q_push    = in_tvalid && in_tready;

  // Classify: range and size failures resolve here, the rest go to the back end
  always_comb begin
    q_cmd        = '0;
    q_cmd.count  = count;
    q_cmd.idx    = block_index;
    q_cmd.kind   = bba_pkg::KIND_STATUS;
    q_cmd.status = bba_pkg::ST_OK;
    if (op == bba_pkg::OP_FREE) begin
      if ({1'b0, block_index} >= lim) begin
        q_cmd.status = bba_pkg::ST_RANGE;
      end else begin
        q_cmd.kind = bba_pkg::KIND_FREE;
      end
    end else if (count == '0) begin
      q_cmd.status = bba_pkg::ST_OK;
    end else if (count > MAX_REQ) begin
      q_cmd.status = bba_pkg::ST_NOSPACE;
    end else begin
      q_cmd.kind = bba_pkg::KIND_ALLOC;
    end
  end

endmodule

`default_nettype wire

FILE: src/bba_queue.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator command queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bba_pkg::cmd_t push_cmd,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               pop_valid,
  output bba_pkg::cmd_t      pop_cmd
);

  bba_pkg::cmd_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = ent_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: src/bba_back.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator back end
// Owns the bitmap memory, the hint and the free count; runs commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_back #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bba_pkg::TOT_W-1:0] lim,
  input  wire logic                      q_valid,
  input  wire bba_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  output bba_pkg::bk_status_t            bk_stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bba_pkg::res_t                  out_res
);

  localparam int WW  = bba_pkg::WORD_W;
  localparam int NW  = (MAX_BLOCKS + WW - 1) / WW;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [WAW-1:0] LAST_W = WAW'(NW - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RC_RD  = 4'd2;
  localparam logic [3:0] S_RC_ACC = 4'd3;
  localparam logic [3:0] S_F_RD   = 4'd4;
  localparam logic [3:0] S_F_WR   = 4'd5;
  localparam logic [3:0] S_A_RD   = 4'd6;
  localparam logic [3:0] S_A_LOAD = 4'd7;
  localparam logic [3:0] S_A_EMIT = 4'd8;

  function automatic logic [5:0] popcnt32(input logic [WW-1:0] v);
    logic [5:0] sum;
    logic [3:0] s8;
    sum = '0;
    for (int b = 0; b < 4; b++) begin
      s8 = '0;
      for (int i = 0; i < 8; i++) begin
        s8 = s8 + 4'(v[8*b+i]);
      end
      sum = sum + 6'(s8);
    end
    return sum;
  endfunction

  logic [WW-1:0] mem [NW];
  logic [WW-1:0] rdata_r;
  logic          mem_we;
  logic [WAW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata;

  logic [3:0]     state_r, state_nxt;
  logic [WAW-1:0] wcnt_r, wcnt_nxt;
  logic [WAW-1:0] word_r, word_nxt;
  logic [WW-1:0]  wrk_r, wrk_nxt;
  logic [bba_pkg::TOT_W-1:0] free_r, free_nxt;
  logic [bba_pkg::TOT_W-1:0] hint_r, hint_nxt;
  logic [bba_pkg::CNT_W-1:0] need_r, need_nxt;
  logic [bba_pkg::CNT_W-1:0] got_r, got_nxt;
  logic [bba_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  bba_pkg::res_t out_res_r, out_res_nxt;

  logic          slot_free;
  logic          emit;
  bba_pkg::res_t emit_res;
  logic [31:0]   hint_word, idx_word, lim_word, blk_w;
  logic [WW-1:0] free_vec, low_bit, rc_mask, idx_bit;
  logic [4:0]    pos;
  logic          any_free, last_grant;

  assign slot_free = !out_valid_r || out_ready;
  assign hint_word = 32'(hint_r) >> 5;
  assign idx_word  = 32'(idx_r) >> 5;
  assign lim_word  = 32'(lim) >> 5;
  assign idx_bit   = WW'(1) << idx_r[4:0];

  // Find the lowest free bit of the working word
  assign free_vec = ~wrk_r;
  assign low_bit  = free_vec & (~free_vec + WW'(1));
  assign any_free = |free_vec;
  always_comb begin
    pos = '0;
    for (int i = 0; i < WW; i++) begin
      if (low_bit[i]) begin
        pos = pos | 5'(i);
      end
    end
  end
  assign blk_w      = (32'(word_r) << 5) | 32'(pos);
  assign last_grant = ((got_r + 7'd1) == need_r);

  // Mask of bits below the effective total for the word being counted
  always_comb begin
    if (32'(wcnt_r) < lim_word) begin
      rc_mask = '1;
    end else if (32'(wcnt_r) == lim_word) begin
      rc_mask = (WW'(1) << lim[4:0]) - WW'(1);
    end else begin
      rc_mask = '0;
    end
  end

  // Command sequencer
  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    word_nxt  = word_r;
    wrk_nxt   = wrk_r;
    free_nxt  = free_r;
    hint_nxt  = hint_r;
    need_nxt  = need_r;
    got_nxt   = got_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    mem_we    = 1'b0;
    mem_waddr = wcnt_r;
    mem_wdata = '0;
    mem_raddr = wcnt_r;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        wcnt_nxt = wcnt_r + WAW'(1);
        if (wcnt_r == LAST_W) begin
          wcnt_nxt  = '0;
          free_nxt  = '0;
          hint_nxt  = '0;
          state_nxt = S_RC_RD;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            bba_pkg::KIND_STATUS: begin
              if (slot_free) begin
                emit            = 1'b1;
                emit_res.status = q_cmd.status;
                emit_res.last   = 1'b1;
                q_pop           = 1'b1;
              end
            end
            bba_pkg::KIND_ALLOC: begin
              if ({4'b0, q_cmd.count} > free_r) begin
                if (slot_free) begin
                  emit            = 1'b1;
                  emit_res.status = bba_pkg::ST_NOSPACE;
                  emit_res.last   = 1'b1;
                  q_pop           = 1'b1;
                end
              end else begin
                q_pop     = 1'b1;
                need_nxt  = q_cmd.count;
                got_nxt   = '0;
                word_nxt  = hint_word[WAW-1:0];
                state_nxt = S_A_RD;
              end
            end
            bba_pkg::KIND_FREE: begin
              q_pop     = 1'b1;
              idx_nxt   = q_cmd.idx;
              state_nxt = S_F_RD;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_RC_RD: begin
        mem_raddr = wcnt_r;
        state_nxt = S_RC_ACC;
      end
      S_RC_ACC: begin
        free_nxt = free_r + bba_pkg::TOT_W'(popcnt32(~rdata_r & rc_mask));
        if (wcnt_r == LAST_W) begin
          state_nxt = S_IDLE;
        end else begin
          wcnt_nxt  = wcnt_r + WAW'(1);
          state_nxt = S_RC_RD;
        end
      end
      S_F_RD: begin
        mem_raddr = idx_word[WAW-1:0];
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        // Keep reading the same word so the data holds through an output stall
        mem_raddr = idx_word[WAW-1:0];
        if (slot_free) begin
          emit            = 1'b1;
          emit_res.status = bba_pkg::ST_OK;
          emit_res.last   = 1'b1;
          if ((rdata_r & idx_bit) != '0) begin
            mem_we    = 1'b1;
            mem_waddr = idx_word[WAW-1:0];
            mem_wdata = rdata_r & ~idx_bit;
            free_nxt  = free_r + bba_pkg::TOT_W'(1);
            if ({1'b0, idx_r} < hint_r) begin
              hint_nxt = {1'b0, idx_r};
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_A_RD: begin
        mem_raddr = word_r;
        state_nxt = S_A_LOAD;
      end
      S_A_LOAD: begin
        wrk_nxt   = rdata_r;
        state_nxt = S_A_EMIT;
      end
      S_A_EMIT: begin
        if (!any_free) begin
          // Word exhausted: write it back and move on
          mem_we    = 1'b1;
          mem_waddr = word_r;
          mem_wdata = wrk_r;
          word_nxt  = word_r + WAW'(1);
          state_nxt = S_A_RD;
        end else if (slot_free) begin
          emit             = 1'b1;
          emit_res.granted = blk_w[bba_pkg::IDX_W-1:0];
          emit_res.status  = bba_pkg::ST_OK;
          emit_res.last    = last_grant;
          wrk_nxt          = wrk_r | low_bit;
          got_nxt          = got_r + 7'd1;
          if (last_grant) begin
            mem_we    = 1'b1;
            mem_waddr = word_r;
            mem_wdata = wrk_r | low_bit;
            hint_nxt  = bba_pkg::TOT_W'(blk_w + 32'd1);
            free_nxt  = free_r - {4'b0, need_r};
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Restart the recount on a register write once the bitmap is cleared
    if (cfg_we && (state_r != S_CLEAR)) begin
      wcnt_nxt  = '0;
      free_nxt  = '0;
      hint_nxt  = '0;
      state_nxt = S_RC_RD;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wcnt_r      <= '0;
      free_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      free_r      <= free_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    wrk_r     <= wrk_nxt;
    need_r    <= need_nxt;
    got_r     <= got_nxt;
    idx_r     <= idx_nxt;
    out_res_r <= out_res_nxt;
  end

  // Bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_res           = out_res_r;
  assign bk_stat.init_done = (state_r != S_CLEAR);
  assign bk_stat.busy      = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a used/free bitmap with hint and free count.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | slave     | tvalid/tready      | tuser op, tdata count, index
//  out_     | master    | tvalid/tready      | tdata block, status; tlast
//  cfg_     | write     | we                 | wdata total_blocks
//
//  Status-only results are emitted straight from the idle state; a free
//  does a memory read, then a write. An allocate reads, loads and scans
//  each 32-bit bitmap word visited and grants blocks while the output is
//  free. After reset a clearing pass over all bitmap words blocks input,
//  then a recount runs; a total_blocks write also starts the recount.
//  A two-entry queue lets input run ahead of a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // count[6:0], block_index[16:7], zero
  input  wire logic        in_tuser,   // op[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // granted_block[9:0], status[11:10], zero
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);

  localparam logic [bba_pkg::TOT_W-1:0] CLIP =
    (MAX_BLOCKS > 2047) ? 11'd2047 : bba_pkg::TOT_W'(MAX_BLOCKS);
  localparam logic [bba_pkg::TOT_W-1:0] RESET_LIM =
    (bba_pkg::RESET_TOTAL < CLIP) ? bba_pkg::RESET_TOTAL : CLIP;

  logic [bba_pkg::TOT_W-1:0] lim_r, lim_nxt;
  bba_pkg::bk_status_t bk_stat;
  bba_pkg::cmd_t       push_cmd, pop_cmd;
  bba_pkg::res_t       out_res;
  logic                q_push, q_ready, q_pop, q_valid;

  // Saturate the written total at the bitmap size
  assign lim_nxt = cfg_we ? ((cfg_wdata < CLIP) ? cfg_wdata : CLIP) : lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= RESET_LIM;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  bba_front #(
    .MAX_REQUEST (MAX_REQUEST)
  ) u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .op          (in_tuser),
    .count       (in_tdata[6:0]),
    .block_index (in_tdata[16:7]),
    .lim         (lim_r),
    .bk_stat     (bk_stat),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  bba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  bba_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .lim       (lim_r),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .bk_stat   (bk_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0, out_res.status, out_res.granted};
  assign out_tlast = out_res.last;

  // Checks
  `BBA_ASSERT_IMP(a_no_accept_in_clear, !bk_stat.init_done, !in_tready)
  `BBA_ASSERT_NXT(a_accept_queues, in_tvalid && in_tready, q_valid)
  `BBA_ASSERT_IMP(a_partial_while_busy, out_tvalid && !out_tlast, bk_stat.busy)
  `BBA_ASSERT_IMP(a_pop_only_valid, q_pop, q_valid && bk_stat.init_done)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free transactions over the input stream, predicts the
// granted blocks from a local bitmap, hint and free count, and checks every
// result in order. Covers directed corner cases, several total_blocks
// settings, random traffic under varied idling and a long receiver hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_BLOCKS    = 1024;
  localparam int MAX_GRANT     = 64;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  typedef logic [bba_pkg::CNT_W-1:0] cnt_t;
  typedef logic [bba_pkg::IDX_W-1:0] idx_t;
  typedef logic [bba_pkg::TOT_W-1:0] tot_t;
  typedef logic [bba_pkg::ST_W-1:0]  st_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [23:0]       in_tdata   = '0;   // count[6:0], block_index[16:7], zero
  logic              in_tuser   = 1'b0; // op[0]
  logic              out_tready = 1'b0;
  logic              cfg_we     = 1'b0;
  tot_t              cfg_wdata  = '0;
  wire logic         in_tready;
  wire logic         out_tvalid;
  wire logic [15:0]  out_tdata;         // granted_block[9:0], status[11:10], zero
  wire logic         out_tlast;

  // Allocator mirror: bitmap, lowest-free hint, free count, register
  bit          used_bits [NUM_BLOCKS];
  int unsigned hint_blk;
  int unsigned free_blocks;
  int unsigned total_reg;

  bba_pkg::res_t pending_grants[$];
  int unsigned   held_blocks[$];

  int items_sent;
  int results_checked;
  int mismatches;
  int cfg_writes;
  int send_gap_pct;
  int stall_pct;
  int hold_left;

  bitmap_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("timeout: %0d results still pending", pending_grants.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned usable_blocks();
    return (total_reg > NUM_BLOCKS) ? NUM_BLOCKS : total_reg;
  endfunction

  function automatic void recount_free();
    int unsigned lim;
    lim = usable_blocks();
    free_blocks = 0;
    for (int unsigned i = 0; i < lim; i++)
      if (!used_bits[i[bba_pkg::IDX_W-1:0]]) free_blocks++;
  endfunction

  function automatic void push_grant(input int unsigned blk, input st_t st,
                                     input logic last);
    bba_pkg::res_t r;
    r.granted = blk[bba_pkg::IDX_W-1:0];
    r.status  = st;
    r.last    = last;
    pending_grants.push_back(r);
  endfunction

  // Work out the results of one accepted transaction and update the mirror
  function automatic void predict_grants(input logic op, input cnt_t cnt,
                                         input idx_t idx);
    int unsigned lim;
    int unsigned i;
    int unsigned got;
    lim = usable_blocks();
    if (op == bba_pkg::OP_FREE) begin
      if (32'(idx) >= lim) begin
        push_grant(0, bba_pkg::ST_RANGE, 1'b1);
      end else begin
        if (used_bits[idx]) begin
          used_bits[idx] = 1'b0;
          free_blocks++;
          if (32'(idx) < hint_blk) hint_blk = 32'(idx);
        end
        push_grant(0, bba_pkg::ST_OK, 1'b1);
      end
    end else if (cnt == '0) begin
      push_grant(0, bba_pkg::ST_OK, 1'b1);
    end else if (32'(cnt) > MAX_GRANT || 32'(cnt) > free_blocks) begin
      push_grant(0, bba_pkg::ST_NOSPACE, 1'b1);
    end else begin
      // First fit from the hint upward
      i   = hint_blk;
      got = 0;
      while (i < lim && got < 32'(cnt)) begin
        if (!used_bits[i[bba_pkg::IDX_W-1:0]]) begin
          used_bits[i[bba_pkg::IDX_W-1:0]] = 1'b1;
          push_grant(i, bba_pkg::ST_OK, (got + 1 == 32'(cnt)));
          held_blocks.push_back(i);
          got++;
        end
        i++;
      end
      free_blocks -= got;
      hint_blk = i;
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  // Stall at random, or hold off completely while a hold is counting down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void note_failure(input string what, input bba_pkg::res_t want,
                                       input bba_pkg::res_t got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s: expected block %0d status %0d last %0d, got block %0d status %0d last %0d",
               $realtime, what, want.granted, want.status, want.last,
               got.granted, got.status, got.last);
    mismatches++;
  endfunction

  // Compare each result transaction with the oldest pending grant
  always @(posedge clk) begin
    bba_pkg::res_t got;
    bba_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.granted = out_tdata[bba_pkg::IDX_W-1:0];
      got.status  = out_tdata[bba_pkg::IDX_W+bba_pkg::ST_W-1:bba_pkg::IDX_W];
      got.last    = out_tlast;
      if (pending_grants.size() == 0) begin
        note_failure("result with nothing pending", '0, got);
      end else begin
        want = pending_grants.pop_front();
        results_checked++;
        if (got.granted !== want.granted || got.status !== want.status ||
            got.last !== want.last)
          note_failure("result differs", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_item(input logic op, input cnt_t cnt, input idx_t idx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, idx, cnt};
    do @(posedge clk); while (!in_tready);
    predict_grants(op, cnt, idx);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  // Write total_blocks once the block has gone quiet
  task automatic write_total(input tot_t value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    total_reg = 32'(value);
    hint_blk  = 0;
    recount_free();
    cfg_writes++;
  endtask

  // Mostly allocations and frees of granted blocks, some stray frees
  task automatic send_random_item();
    int unsigned r;
    int unsigned pick;
    cnt_t cnt;
    idx_t idx;
    r = $urandom_range(99);
    if (r < 50) begin
      pick = $urandom_range(99);
      if (pick < 70)      cnt = cnt_t'($urandom_range(8, 1));
      else if (pick < 90) cnt = cnt_t'($urandom_range(MAX_GRANT, 9));
      else if (pick < 95) cnt = '0;
      else                cnt = cnt_t'($urandom_range(127, MAX_GRANT + 1));
      send_item(bba_pkg::OP_ALLOC, cnt, idx_t'($urandom_range(NUM_BLOCKS - 1)));
    end else if (r < 90 && held_blocks.size() > 0) begin
      pick = $urandom_range(held_blocks.size() - 1);
      idx  = idx_t'(held_blocks[pick]);
      held_blocks.delete(pick);
      send_item(bba_pkg::OP_FREE, cnt_t'($urandom_range(127)), idx);
    end else begin
      send_item(bba_pkg::OP_FREE, cnt_t'($urandom_range(127)),
                idx_t'($urandom_range(NUM_BLOCKS - 1)));
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Corner cases: empty, maximum and oversized requests, hint rewind,
  // double free, range errors, zero and saturated totals
  task automatic test_directed();
    send_item(bba_pkg::OP_ALLOC, 7'd0, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd64, 10'h3FF);
    send_item(bba_pkg::OP_ALLOC, 7'd65, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd127, 10'h3FF);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd0);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd0);
    send_item(bba_pkg::OP_FREE, 7'd127, 10'd1023);
    send_item(bba_pkg::OP_ALLOC, 7'd3, 10'd0);
    write_total(11'd5);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd5);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd2);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    write_total(11'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd0, 10'd0);
    write_total(11'h7FF);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd1023);
    send_item(bba_pkg::OP_ALLOC, 7'd64, 10'd0);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd64);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd1);
    send_item(bba_pkg::OP_ALLOC, 7'd2, 10'd0);
    write_total(11'd1);
    send_item(bba_pkg::OP_FREE, 7'd0, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 7'd1, 10'd0);
    wait_for_results();
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_receiver_hold();
    send_gap_pct = 0;
    stall_pct    = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (8) send_item(bba_pkg::OP_ALLOC, 7'd2, 10'd0);
    repeat (8) send_random_item();
    wait_for_results();
  endtask

  task automatic run_random_phase(input tot_t total, input int gap_pct,
                                  input int stall, input int n);
    write_total(total);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    repeat (n) send_random_item();
    wait_for_results();
  endtask

  initial begin
    used_bits    = '{default: 1'b0};
    total_reg    = 32'(bba_pkg::RESET_TOTAL);
    hint_blk     = 0;
    free_blocks  = 32'(bba_pkg::RESET_TOTAL);
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_left    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    run_random_phase(11'd1024, 0, 0, 120);
    test_receiver_hold();
    run_random_phase(11'd200, 50, 0, 110);
    run_random_phase(11'h7FF, 0, 50, 110);
    run_random_phase(11'd60, 7, 7, 110);

    send_gap_pct = 0;
    stall_pct    = 0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run: %0d transactions in, %0d results checked, %0d total_blocks writes",
             items_sent, results_checked, cfg_writes);
    $display("traffic: steady, sender gaps, receiver stalls, both, and one long hold");
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: bitmap_block_allocator.f
+incdir+src
src/bba_pkg.sv
src/bba_front.sv
src/bba_queue.sv
src/bba_back.sv
src/bitmap_block_allocator.sv
tb/tb_top.sv
